### src/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants for the key click classifier
// Phase encoding, register indexes, reset values and stream widths.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

  localparam int unsigned WINDOW_WIDTH    = 8;
  localparam int unsigned THRESHOLD_WIDTH = 16;
  localparam int unsigned GAP_WIDTH       = 9;
  localparam int unsigned HELD_WIDTH      = 16;
  localparam int unsigned TOTAL_WIDTH     = 16;

  localparam int unsigned CFG_ADDR_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_DOUBLE_WINDOW   = 1'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_THRESHOLD  = 1'd1;

  localparam logic [WINDOW_WIDTH-1:0]    WINDOW_RESET    = 8'd20;
  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 16'd100;

  localparam logic [HELD_WIDTH-1:0] HELD_MAX = {HELD_WIDTH{1'b1}};

  // s side: key_released in bit 0
  localparam int unsigned S_TDATA_WIDTH = 8;
  // m side: four flags and three totals, padded to whole bytes
  localparam int unsigned M_PAYLOAD_WIDTH = 4 + 3 * TOTAL_WIDTH;
  localparam int unsigned M_TDATA_WIDTH   = ((M_PAYLOAD_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_HELD  = 2'd2
  } phase_t;

endpackage

### src/key_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// key_click_classifier_unit: single, double and long press detector
// Classifies one active-low key sample per item and counts each event kind.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one key sample per item (tdata bit 0 = key_released,
//   1 released, 0 pressed). Each accepted item yields exactly one m_axis
//   item with the raw pressed level, three one-item event pulses (single,
//   long, double) and the three wrapping event totals.
//   The result item is registered and is valid in the cycle after its
//   sample is accepted. Throughput is one item per cycle while results are
//   taken; the whole tracker update sits between the state and result registers.
//   When the receiver stalls, the result register holds its item and
//   s_axis_tready drops until it is taken; no item is lost or repeated.
//   cfg_we/cfg_addr/cfg_wdata write double_click_window (index 0, 8 bit)
//   and long_press_threshold (index 1, 16 bit); write only while idle.
//   Reset (rst, synchronous) clears the tracker, the totals and the result
//   valid flag, and restores the window to 20 and the threshold to 100.
// ----------------------------------------------------------------------------
module key_click_classifier_unit #(
  parameter int unsigned COUNT_WIDTH = kcc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] key_released, [7:1] zero
  input  logic [kcc_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] pressed_now, [1] single_click, [2] long_press, [3] double_click,
  // [19:4] single_total, [35:20] long_total, [51:36] double_total, [55:52] zero
  output logic [kcc_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [kcc_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [kcc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
  import kcc_pkg::*;

  logic [WINDOW_WIDTH-1:0]    double_click_window;
  logic [THRESHOLD_WIDTH-1:0] long_press_threshold;

  phase_t                 scan_phase, scan_phase_next;
  logic [HELD_WIDTH-1:0]  held_ticks, held_ticks_next;
  logic [GAP_WIDTH-1:0]   gap_ticks, gap_ticks_next;
  logic                   gap_open, gap_open_next;
  logic                   single_pending, single_pending_next;
  logic                   second_press, second_press_next;

  logic [COUNT_WIDTH-1:0] single_count, single_count_next;
  logic [COUNT_WIDTH-1:0] long_count, long_count_next;
  logic [COUNT_WIDTH-1:0] double_count, double_count_next;

  logic released;
  logic hit_single, hit_long, hit_double;
  logic accept;

  logic                   out_pressed, out_single, out_long, out_double;
  logic [TOTAL_WIDTH-1:0] out_single_total, out_long_total, out_double_total;

  assign released      = s_axis_tdata[0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_window  <= WINDOW_RESET;
      long_press_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DOUBLE_WINDOW:  double_click_window  <= cfg_wdata[WINDOW_WIDTH-1:0];
        REG_LONG_THRESHOLD: long_press_threshold <= cfg_wdata[THRESHOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // tracker update for one sample
  always_comb begin
    logic [GAP_WIDTH-1:0]  gap_inc;
    logic [HELD_WIDTH-1:0] held_inc;

    scan_phase_next     = scan_phase;
    held_ticks_next     = held_ticks;
    gap_ticks_next      = gap_ticks;
    gap_open_next       = gap_open;
    single_pending_next = single_pending;
    second_press_next   = second_press;
    hit_single          = 1'b0;
    hit_long            = 1'b0;
    hit_double          = 1'b0;

    // advance the gap window; on expiry flush a waiting single click
    gap_inc = gap_ticks + GAP_WIDTH'(1);
    if (gap_open) begin
      gap_ticks_next = gap_inc;
      if (gap_inc > {1'b0, double_click_window}) begin
        hit_single          = single_pending;
        single_pending_next = 1'b0;
        gap_open_next       = 1'b0;
        gap_ticks_next      = '0;
      end
    end

    held_inc = (held_ticks != HELD_MAX) ? held_ticks + HELD_WIDTH'(1) : held_ticks;

    case (scan_phase)
      PH_FIRST: begin
        if (!released) begin
          // gap still open here means it is within the window
          if (gap_open_next) begin
            second_press_next   = 1'b1;
            single_pending_next = 1'b0;
          end else begin
            second_press_next = 1'b0;
          end
          scan_phase_next = PH_HELD;
        end else begin
          scan_phase_next = PH_IDLE;
        end
      end
      PH_HELD: begin
        held_ticks_next = held_inc;
        if (released) begin
          if (!second_press) begin
            if (held_inc > long_press_threshold) begin
              hit_long = 1'b1;
            end else begin
              single_pending_next = 1'b1;
            end
          end else begin
            hit_double = 1'b1;
          end
          scan_phase_next = PH_IDLE;
          held_ticks_next = '0;
          gap_open_next   = 1'b1;
        end
      end
      default: begin
        scan_phase_next = released ? PH_IDLE : PH_FIRST;
      end
    endcase

    single_count_next = hit_single ? single_count + COUNT_WIDTH'(1) : single_count;
    long_count_next   = hit_long   ? long_count   + COUNT_WIDTH'(1) : long_count;
    double_count_next = hit_double ? double_count + COUNT_WIDTH'(1) : double_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase     <= PH_IDLE;
      held_ticks     <= '0;
      gap_ticks      <= '0;
      gap_open       <= 1'b0;
      single_pending <= 1'b0;
      second_press   <= 1'b0;
      single_count   <= '0;
      long_count     <= '0;
      double_count   <= '0;
    end else if (accept) begin
      scan_phase     <= scan_phase_next;
      held_ticks     <= held_ticks_next;
      gap_ticks      <= gap_ticks_next;
      gap_open       <= gap_open_next;
      single_pending <= single_pending_next;
      second_press   <= second_press_next;
      single_count   <= single_count_next;
      long_count     <= long_count_next;
      double_count   <= double_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pressed      <= !released;
      out_single       <= hit_single;
      out_long         <= hit_long;
      out_double       <= hit_double;
      out_single_total <= TOTAL_WIDTH'(single_count_next);
      out_long_total   <= TOTAL_WIDTH'(long_count_next);
      out_double_total <= TOTAL_WIDTH'(double_count_next);
    end
  end

  assign m_axis_tdata = {
    {(M_TDATA_WIDTH - M_PAYLOAD_WIDTH){1'b0}},
    out_double_total, out_long_total, out_single_total,
    out_double, out_long, out_single, out_pressed
  };

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item did not produce a result");

  a_held_only_when_held: assert property (@(posedge clk) disable iff (rst)
    (held_ticks != '0) |-> (scan_phase == PH_HELD))
    else $error("held count nonzero outside held phase");

  a_gap_only_when_open: assert property (@(posedge clk) disable iff (rst)
    (gap_ticks != '0) |-> gap_open)
    else $error("gap count running with window closed");

  a_release_events: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_long || out_double)) |-> !out_pressed)
    else $error("long or double event on a pressed sample");
`endif

endmodule
